FILE: rtl/core/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// shared widths, register codes, order codes and control struct for the
// stereo polynomial predictor
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ORDER_WIDTH  = 2;
    localparam int CUT_WIDTH    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int WARM_WIDTH   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOSSY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUT   = 2'd2;

    localparam logic [ORDER_WIDTH-1:0] ORDER_ZERO  = 2'd0;
    localparam logic [ORDER_WIDTH-1:0] ORDER_ONE   = 2'd1;
    localparam logic [ORDER_WIDTH-1:0] ORDER_TWO   = 2'd2;
    localparam logic [ORDER_WIDTH-1:0] ORDER_THREE = 2'd3;

    localparam logic [WARM_WIDTH-1:0] WARM_FULL = 2'd3;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        logic [ORDER_WIDTH-1:0] order;
        logic                   use_est;
        logic                   lossy;
        logic [CUT_WIDTH-1:0]   cut;
    } pred_ctl_t;

endpackage

FILE: rtl/core/spp_channel.sv
// ----------------------------------------------------------------------------
// spp_channel
// one channel: three-deep sample history, fixed polynomial estimate,
// wrapped residual and optional arithmetic right shift
// ----------------------------------------------------------------------------
module spp_channel
    import spp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  pred_ctl_t ctl,
    input  sample_t   sample,
    output sample_t   residual
);

    sample_t h0_reg, h1_reg, h2_reg;
    sample_t est;
    sample_t diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h0_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
        end else if (advance) begin
            h0_reg <= sample;
            h1_reg <= h0_reg;
            h2_reg <= h1_reg;
        end
    end

    always_comb begin
        est = '0;
        if (ctl.use_est) begin
            unique case (ctl.order)
                ORDER_ONE:   est = h0_reg;
                ORDER_TWO:   est = (h0_reg <<< 1) - h1_reg;
                ORDER_THREE: est = (h0_reg <<< 1) + h0_reg - (h1_reg <<< 1) - h1_reg + h2_reg;
                ORDER_ZERO:  est = (h0_reg <<< 1) + h0_reg - (h1_reg <<< 1) - h1_reg + h2_reg;
                default:     est = '0;
            endcase
        end
        diff = sample - est;
    end

    assign residual = ctl.lossy ? (diff >>> ctl.cut) : diff;

endmodule

FILE: rtl/core/stereo_polynomial_predictor_top.sv
// ----------------------------------------------------------------------------
// stereo_polynomial_predictor_top
// stereo fixed polynomial predictor of order one to three with optional
// lossy right shift of the residuals
// ----------------------------------------------------------------------------
// Each accepted frame gives one residual frame in the following cycle through a
// single output register; a new frame is taken in every cycle while the
// output register is empty or being drained, so throughput is one frame per
// clock. The estimate, residual and shift for both channels sit between the
// sample history registers and the output register. Configuration writes
// take effect at once and are meant for idle periods.
module stereo_polynomial_predictor_top
    import spp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_t               s_left_sample,
    input  sample_t               s_right_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sample_t               m_left_residual,
    output sample_t               m_right_residual
);

    logic [ORDER_WIDTH-1:0] order_reg;
    logic                   lossy_reg;
    logic [CUT_WIDTH-1:0]   cut_reg;
    logic [WARM_WIDTH-1:0]  warm_reg;
    logic [WARM_WIDTH-1:0]  warm_next;
    logic [ORDER_WIDTH-1:0] eff_order;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    sample_t                left_res_reg;
    sample_t                right_res_reg;
    sample_t                left_res;
    sample_t                right_res;
    logic                   in_xfer;
    pred_ctl_t              ctl;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    // order zero behaves as order three
    assign eff_order = (order_reg == ORDER_ZERO) ? ORDER_THREE : order_reg;

    assign ctl.order   = order_reg;
    assign ctl.use_est = (warm_reg >= eff_order);
    assign ctl.lossy   = lossy_reg;
    assign ctl.cut     = cut_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_ONE;
            lossy_reg <= 1'b0;
            cut_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_ORDER: order_reg <= cfg_wr_data[ORDER_WIDTH-1:0];
                REG_LOSSY: lossy_reg <= cfg_wr_data[0];
                REG_CUT:   cut_reg   <= cfg_wr_data[CUT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        warm_next = warm_reg;
        if (in_xfer && (warm_reg != WARM_FULL)) begin
            warm_next = warm_reg + 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (in_xfer) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warm_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            warm_reg    <= warm_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            left_res_reg  <= left_res;
            right_res_reg <= right_res;
        end
    end

    spp_channel u_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (in_xfer),
        .ctl      (ctl),
        .sample   (s_left_sample),
        .residual (left_res)
    );

    spp_channel u_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (in_xfer),
        .ctl      (ctl),
        .sample   (s_right_sample),
        .residual (right_res)
    );

    assign m_valid          = m_valid_reg;
    assign m_left_residual  = left_res_reg;
    assign m_right_residual = right_res_reg;

    a_empty_takes_input : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled while output register empty");

    a_transfer_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_valid)
        else $error("accepted frame produced no result");

    a_warm_counts : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (warm_reg != WARM_FULL)) |=> (warm_reg == $past(warm_reg) + 1'b1))
        else $error("warm-up count missed a transfer");

    a_warm_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !in_xfer |=> $stable(warm_reg))
        else $error("warm-up count moved without a transfer");

endmodule

FILE: tb/sv/tb_stereo_polynomial_predictor_top.sv
// ----------------------------------------------------------------------------
// tb_stereo_polynomial_predictor_top
// self-checking testbench for the stereo fixed polynomial predictor
// ----------------------------------------------------------------------------
// A short scripted sequence covers warm-up after reset, an order change in
// mid-stream, order zero, wrap-around of estimate and residual, the lossy
// shift at both ends of its range, cut bits in lossless mode and a write to
// the unused register index. Random phases follow, each under a random
// register setting, with smooth, extreme and noisy sample streams. Every
// residual frame is checked against an in-bench predictor or a typed value;
// both sides of the link idle in random bursts except in the final phase.
module tb_stereo_polynomial_predictor_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES       = 6;
    localparam int PHASE_FRAMES = 150;
    localparam int NUM_ROWS     = 28;

    typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               left;
        sample_t               right;
        logic                  typed;
        sample_t               exp_left;
        sample_t               exp_right;
    } stim_row_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } residual_pair_t;

    localparam stim_row_t SCRIPT [NUM_ROWS] = '{
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF},
        '{ROW_WRITE, REG_ORDER, CFG_DATA_W'(ORDER_THREE), 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh0001, 16'shFFFF, 1'b1, 16'sh0001, 16'shFFFF},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh1234, 16'shEDCC, 1'b1, 16'sh1234, 16'shEDCC},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_ORDER, CFG_DATA_W'(ORDER_ZERO), 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh0000, 16'sh0000, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_ORDER, CFG_DATA_W'(ORDER_ONE), 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh0001, 16'shFFFF},
        '{ROW_WRITE, REG_ORDER, CFG_DATA_W'(ORDER_TWO), 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh1000, 16'shF000, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_LOSSY, 4'd1, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_CUT, 4'd15, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh5555, 16'shAAAA, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_CUT, 4'd0, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh0123, 16'shFEDC, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_LOSSY, 4'd0, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_CUT, 4'd7, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_SPARE, 4'd15, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, REG_ORDER, CFG_DATA_W'(ORDER_THREE), 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'sh4321, 16'shBCDF, 1'b0, 16'sh0, 16'sh0},
        '{ROW_FRAME, REG_ORDER, 4'd0, 16'shFFFF, 16'sh0001, 1'b0, 16'sh0, 16'sh0}
    };

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data    = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    sample_t               s_left_sample  = '0;
    sample_t               s_right_sample = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    sample_t               m_left_residual;
    sample_t               m_right_residual;

    // predictor state and register copies
    logic [SAMPLE_WIDTH-1:0] left_hist [3];
    logic [SAMPLE_WIDTH-1:0] right_hist [3];
    logic [WARM_WIDTH-1:0]   warm_frames;
    logic [ORDER_WIDTH-1:0]  order_reg;
    logic                    lossy_reg;
    logic [CUT_WIDTH-1:0]    cut_reg;

    residual_pair_t pending_residuals [$];
    int             mismatches = 0;
    bit             calm       = 1'b0;
    int             ready_left = 0;

    stereo_polynomial_predictor_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic sample_t channel_residual(sample_t x, logic [SAMPLE_WIDTH-1:0] h0,
                                                 logic [SAMPLE_WIDTH-1:0] h1,
                                                 logic [SAMPLE_WIDTH-1:0] h2, int ord);
        logic [SAMPLE_WIDTH-1:0] est;
        sample_t                 diff;
        est = '0;
        if (warm_frames >= ord) begin
            case (ord)
                1:       est = h0;
                2:       est = SAMPLE_WIDTH'(2 * h0 - h1);
                default: est = SAMPLE_WIDTH'(3 * h0 - 3 * h1 + h2);
            endcase
        end
        diff = x - est;
        if (lossy_reg) begin
            diff = diff >>> cut_reg;
        end
        return diff;
    endfunction

    function automatic residual_pair_t predict_frame(sample_t l, sample_t r);
        residual_pair_t res;
        int             ord;
        ord = (order_reg == ORDER_ZERO) ? 3 : int'(order_reg);
        res.left  = channel_residual(l, left_hist[0], left_hist[1], left_hist[2], ord);
        res.right = channel_residual(r, right_hist[0], right_hist[1], right_hist[2], ord);
        left_hist[2]  = left_hist[1];
        left_hist[1]  = left_hist[0];
        left_hist[0]  = l;
        right_hist[2] = right_hist[1];
        right_hist[1] = right_hist[0];
        right_hist[0] = r;
        if (warm_frames != WARM_FULL) begin
            warm_frames = warm_frames + 1'b1;
        end
        return res;
    endfunction

    function automatic sample_t next_sample(sample_t prev);
        sample_t v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7FFF;
                    2:       v = 16'sh0000;
                    default: v = 16'shFFFF;
                endcase
            end
            1, 2, 3: v = sample_t'($urandom);
            default: v = prev + sample_t'($urandom_range(0, 1024)) - 16'sd512;
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ORDER: order_reg = data[ORDER_WIDTH-1:0];
            REG_LOSSY: lossy_reg = data[0];
            REG_CUT:   cut_reg   = data[CUT_WIDTH-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // drain every outstanding residual, then allow for the output register
    task automatic settle();
        s_valid <= 1'b0;
        wait (pending_residuals.size() == 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic send_frame(sample_t l, sample_t r, logic typed, residual_pair_t typed_res);
        residual_pair_t res;
        int             gap;
        s_valid        <= 1'b1;
        s_left_sample  <= l;
        s_right_sample <= r;
        do @(posedge aclk); while (!s_ready);
        res = predict_frame(l, r);
        pending_residuals.insert(pending_residuals.size(), typed ? typed_res : res);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (ready_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(0, 17);
            end else begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(1, 40);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    always @(posedge aclk) begin
        residual_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_residuals.size() == 0) begin
                $error("residual transfer with nothing expected");
                mismatches++;
            end else begin
                want = pending_residuals.pop_front();
                if (m_left_residual !== want.left) begin
                    $error("left_residual: expected %0d, got %0d", want.left, m_left_residual);
                    mismatches++;
                end
                if (m_right_residual !== want.right) begin
                    $error("right_residual: expected %0d, got %0d", want.right,
                           m_right_residual);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        sample_t        left_prev;
        sample_t        right_prev;
        residual_pair_t none;
        int             ph;
        int             n;
        order_reg   = ORDER_ONE;
        lossy_reg   = 1'b0;
        cut_reg     = '0;
        warm_frames = '0;
        left_prev   = '0;
        right_prev  = '0;
        none        = '0;
        foreach (left_hist[i]) begin
            left_hist[i]  = '0;
            right_hist[i] = '0;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_WRITE) begin
                settle();
                write_reg(SCRIPT[i].idx, SCRIPT[i].data);
            end else begin
                send_frame(SCRIPT[i].left, SCRIPT[i].right, SCRIPT[i].typed,
                           residual_pair_t'{SCRIPT[i].exp_left, SCRIPT[i].exp_right});
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            calm = (ph == PHASES - 1);
            write_reg(REG_ORDER, CFG_DATA_W'($urandom_range(0, 15)));
            write_reg(REG_LOSSY, CFG_DATA_W'($urandom_range(0, 15)));
            write_reg(REG_CUT, CFG_DATA_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 1) == 1) begin
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 15)));
            end
            for (n = 0; n < PHASE_FRAMES; n++) begin
                left_prev  = next_sample(left_prev);
                right_prev = next_sample(right_prev);
                send_frame(left_prev, right_prev, 1'b0, none);
            end
        end

        settle();
        if (pending_residuals.size() != 0) begin
            $error("%0d residual transfers never arrived", pending_residuals.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
